// File: rtl/channel_histogram_min_max_assert.svh
// Assertion macros used by the checker of the histogram block.
// Each macro expects a signal named clock in the scope where it is used; the first two also use reset.
`ifndef CHANNEL_HISTOGRAM_MIN_MAX_ASSERT_SVH
`define CHANNEL_HISTOGRAM_MIN_MAX_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define CHM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define CHM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define CHM_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/chm_pkg.sv
`default_nettype none

package chm_pkg;

   // Defaults for the top-level parameters.
   localparam int BINS_MAX_DEF    = 1024;
   localparam int COUNT_WIDTH_DEF = 16;

   // Fixed field widths.
   localparam int SAMPLE_W = 16;
   localparam int BIN_W    = 10;
   localparam int OUT_W    = 16;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam int NUM_HIST  = 3;
   localparam int NUM_TRACK = 4;

   localparam int QUEUE_DEPTH = 2;

   // Bin shift per sample format and bin count.
   localparam logic [3:0] SHIFT_10B_256  = 4'd2;
   localparam logic [3:0] SHIFT_10B_1024 = 4'd0;
   localparam logic [3:0] SHIFT_16B_256  = 4'd8;
   localparam logic [3:0] SHIFT_16B_1024 = 4'd6;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_BIN_MODE      = 2'd0;
   localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd1;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

   localparam logic FORMAT_10B = 1'b0;

   // Request kinds as they arrive on the input channel.
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_PIXEL = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   // Operations handed from the front end to the back end.
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_PIXEL = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_WR,
      ST_READ_OUT
   } back_state_type;

   typedef struct packed {
      logic       bin_mode;
      logic       sample_format;
      logic [2:0] channel_count;
   } cfg_type;

   typedef struct packed {
      op_type                               op;
      logic [NUM_HIST-1:0][BIN_W-1:0]       bin;
      logic [NUM_HIST-1:0]                  bin_ok;
      logic [NUM_TRACK-1:0]                 track;
      logic [NUM_TRACK-1:0][SAMPLE_W-1:0]   sample;
      logic [1:0]                           chan_sel;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

`default_nettype wire

// File: rtl/chm_channel_if.sv
`default_nettype none

interface chm_req_if;
   import chm_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [SAMPLE_W-1:0] sample_zero;
   logic [SAMPLE_W-1:0] sample_one;
   logic [SAMPLE_W-1:0] sample_two;
   logic [SAMPLE_W-1:0] sample_three;
   logic [BIN_W-1:0]    bin_index;
   logic [1:0]          channel_select;

   modport source (
      output valid, kind, sample_zero, sample_one, sample_two, sample_three,
             bin_index, channel_select,
      input  ready
   );
   modport sink (
      input  valid, kind, sample_zero, sample_one, sample_two, sample_three,
             bin_index, channel_select,
      output ready
   );
endinterface

interface chm_rsp_if;
   import chm_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] count_first;
   logic [OUT_W-1:0] count_second;
   logic [OUT_W-1:0] count_third;
   logic [OUT_W-1:0] channel_min;
   logic [OUT_W-1:0] channel_max;

   modport source (
      output valid, count_first, count_second, count_third, channel_min, channel_max,
      input  ready
   );
   modport sink (
      input  valid, count_first, count_second, count_third, channel_min, channel_max,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/channel_histogram_min_max.sv
// Per-channel histogram with per-channel minimum and maximum.
// Requests arrive on req_chan (valid/ready). A start request clears the bins and
// the extremes, a pixel request adds one to a bin of each histogrammed channel
// and folds its samples into the extremes, and a read request returns the three
// counts of one bin and the extremes of one channel on rsp_chan (valid/ready).
// Start and pixel requests give no response. Unused kind codes are dropped.
// Three registers on the csr_ port select the bin count, the sample format and
// the channels per pixel; they are to be written only while the block is idle,
// a rule on the user, left unchecked by the block itself. A request enters a
// two-entry queue in the cycle it is accepted. The back end takes a pixel as
// a bank read, then a write of the incremented count, and a read as a bank
// read, then a load of the output register. A start runs a clearing pass over
// all BINS_MAX bins (1024 by default), one bin address of all banks per cycle,
// during which req_chan.ready is low. Reset runs the same pass. A response
// waits in an output register until taken; while it waits, pixels and starts
// behind it keep going, and only a second read stalls the back end. When the
// queue is full, req_chan.ready drops until the back end catches up.
`default_nettype none

module channel_histogram_min_max #(
   parameter int BINS_MAX    = chm_pkg::BINS_MAX_DEF,
   parameter int COUNT_WIDTH = chm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   chm_req_if.sink                    req_chan,
   chm_rsp_if.source                  rsp_chan,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [chm_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [chm_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [chm_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import chm_pkg::*;

   logic         bin_mode_ff, bin_mode_in;
   logic         sample_format_ff, sample_format_in;
   logic [2:0]   channel_count_ff, channel_count_in;
   logic         csr_write;
   logic [1:0]   csr_index;

   cfg_type      cfg;
   push_type     push;
   q_status_type q_status;
   cmd_type      head_cmd;
   logic         pop;
   logic         clearing;

   // Registers sit on a 4-byte stride; the low address bits are not decoded.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      bin_mode_in      = bin_mode_ff;
      sample_format_in = sample_format_ff;
      channel_count_in = channel_count_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_BIN_MODE:      bin_mode_in      = csr_pwdata[0];
            REG_SAMPLE_FORMAT: sample_format_in = csr_pwdata[0];
            REG_CHANNEL_COUNT: channel_count_in = csr_pwdata[2:0];
            default: begin
               bin_mode_in = bin_mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BIN_MODE:      csr_prdata = CSR_DW'(bin_mode_ff);
         REG_SAMPLE_FORMAT: csr_prdata = CSR_DW'(sample_format_ff);
         REG_CHANNEL_COUNT: csr_prdata = CSR_DW'(channel_count_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_mode_ff      <= 1'b0;
         sample_format_ff <= 1'b1;
         channel_count_ff <= 3'd3;
      end else begin
         bin_mode_ff      <= bin_mode_in;
         sample_format_ff <= sample_format_in;
         channel_count_ff <= channel_count_in;
      end
   end

   assign cfg.bin_mode      = bin_mode_ff;
   assign cfg.sample_format = sample_format_ff;
   assign cfg.channel_count = channel_count_ff;

   // The front end turns each request into a bank command with its bins, the
   // channels it touches and the samples it folds into the extremes.
   chm_front #(
      .BINS_MAX (BINS_MAX)
   ) u_front (
      .req_chan (req_chan),
      .cfg      (cfg),
      .q_status (q_status),
      .clearing (clearing),
      .push     (push)
   );

   chm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .q_status (q_status),
      .head_cmd (head_cmd)
   );

   // The back end owns the bin banks, the extremes and the response register.
   chm_back #(
      .BINS_MAX    (BINS_MAX),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head_cmd (head_cmd),
      .pop      (pop),
      .clearing (clearing),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: rtl/chm_front.sv
`default_nettype none

module chm_front #(
   parameter int BINS_MAX = chm_pkg::BINS_MAX_DEF
) (
   chm_req_if.sink              req_chan,
   input  chm_pkg::cfg_type      cfg,
   input  chm_pkg::q_status_type q_status,
   input  logic                  clearing,
   output chm_pkg::push_type     push
);
   import chm_pkg::*;

   logic [NUM_TRACK-1:0][SAMPLE_W-1:0] raw;

   assign raw = {req_chan.sample_three, req_chan.sample_two,
                 req_chan.sample_one, req_chan.sample_zero};

   // The bin store is swept while clearing, so nothing new comes in then.
   assign req_chan.ready = !q_status.full && !clearing;

   always_comb begin
      logic [3:0]                         shift;
      logic [2:0]                         n_chan;
      logic [NUM_HIST-1:0]                hist;
      logic [NUM_TRACK-1:0][SAMPLE_W-1:0] value;
      logic [SAMPLE_W-1:0]                shifted;
      cmd_type                            cmd;

      shift   = SHIFT_16B_256;
      n_chan  = cfg.channel_count;
      hist    = '0;
      value   = raw;
      shifted = '0;
      cmd     = '0;

      if (cfg.sample_format == FORMAT_10B) begin
         shift = cfg.bin_mode ? SHIFT_10B_1024 : SHIFT_10B_256;
         for (int c = 0; c < NUM_TRACK; c++) begin
            value[c] = {{(SAMPLE_W-BIN_W){1'b0}}, raw[c][BIN_W-1:0]};
         end
         hist      = '1;
         cmd.track = 4'b0111;
      end else begin
         shift = cfg.bin_mode ? SHIFT_16B_1024 : SHIFT_16B_256;
         if (cfg.channel_count == 3'd0) begin
            n_chan = 3'd1;
         end else if (cfg.channel_count > 3'd4) begin
            n_chan = 3'd4;
         end
         for (int c = 0; c < NUM_TRACK; c++) begin
            cmd.track[c] = 3'(c) < n_chan;
         end
         for (int c = 0; c < NUM_HIST; c++) begin
            hist[c] = 3'(c) < n_chan;
         end
      end

      cmd.sample   = value;
      cmd.chan_sel = req_chan.channel_select;
      cmd.op       = OP_PIXEL;

      unique case (req_chan.kind)
         KIND_START: begin
            cmd.op = OP_CLEAR;
         end
         KIND_PIXEL: begin
            cmd.op = OP_PIXEL;
            for (int c = 0; c < NUM_HIST; c++) begin
               shifted       = value[c] >> shift;
               cmd.bin[c]    = shifted[BIN_W-1:0];
               cmd.bin_ok[c] = hist[c] && (32'(cmd.bin[c]) < 32'(BINS_MAX));
            end
         end
         KIND_READ: begin
            cmd.op = OP_READ;
            for (int c = 0; c < NUM_HIST; c++) begin
               cmd.bin[c]    = req_chan.bin_index;
               cmd.bin_ok[c] = 32'(req_chan.bin_index) < 32'(BINS_MAX);
            end
         end
         default: begin
            cmd.op = OP_CLEAR;
         end
      endcase

      push.cmd  = cmd;
      // Unused kind codes are accepted and dropped here.
      push.push = req_chan.valid && req_chan.ready &&
                  (req_chan.kind == KIND_START || req_chan.kind == KIND_PIXEL ||
                   req_chan.kind == KIND_READ);
   end

endmodule

`default_nettype wire

// File: rtl/chm_queue.sv
`default_nettype none

module chm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  chm_pkg::push_type     push,
   input  logic                  pop,
   output chm_pkg::q_status_type q_status,
   output chm_pkg::cmd_type      head_cmd
);
   import chm_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign q_status.empty = count_ff == '0;
   assign q_status.full  = count_ff == CntW'(QUEUE_DEPTH);
   assign head_cmd       = entry_ff[rd_ptr_ff];

   assign do_push = push.push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/chm_back.sv
`default_nettype none

module chm_back #(
   parameter int BINS_MAX    = chm_pkg::BINS_MAX_DEF,
   parameter int COUNT_WIDTH = chm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  chm_pkg::q_status_type q_status,
   input  chm_pkg::cmd_type      head_cmd,
   output logic                  pop,
   output logic                  clearing,
   chm_rsp_if.source             rsp_chan
);
   import chm_pkg::*;

   localparam int AddrW = $clog2(BINS_MAX);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(BINS_MAX - 1);

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [AddrW-1:0]     clr_ff, clr_in;
   logic [SAMPLE_W-1:0]  min_ff [NUM_TRACK];
   logic [SAMPLE_W-1:0]  min_in [NUM_TRACK];
   logic [SAMPLE_W-1:0]  max_ff [NUM_TRACK];
   logic [SAMPLE_W-1:0]  max_in [NUM_TRACK];
   logic                 seen_ff, seen_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     count_ff [NUM_HIST];
   logic [OUT_W-1:0]     count_in [NUM_HIST];
   logic [OUT_W-1:0]     out_min_ff, out_min_in;
   logic [OUT_W-1:0]     out_max_ff, out_max_in;

   // One bank per histogrammed channel.
   logic [COUNT_WIDTH-1:0] bank_mem [NUM_HIST][BINS_MAX];
   logic [COUNT_WIDTH-1:0] rd_data_ff [NUM_HIST];
   logic                   rd_en;
   logic [NUM_HIST-1:0]    wr_en;
   logic [AddrW-1:0]       rd_addr [NUM_HIST];
   logic [AddrW-1:0]       wr_addr [NUM_HIST];
   logic [COUNT_WIDTH-1:0] wr_data [NUM_HIST];

   assign clearing = state_ff == ST_CLEAR;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.count_first  = count_ff[0];
   assign rsp_chan.count_second = count_ff[1];
   assign rsp_chan.count_third  = count_ff[2];
   assign rsp_chan.channel_min  = out_min_ff;
   assign rsp_chan.channel_max  = out_max_ff;

   always_comb begin
      for (int c = 0; c < NUM_HIST; c++) begin
         rd_addr[c] = AddrW'(head_cmd.bin[c]);
         wr_addr[c] = (state_ff == ST_CLEAR) ? clr_ff : AddrW'(cmd_ff.bin[c]);
         wr_data[c] = (state_ff == ST_CLEAR) ? '0 : rd_data_ff[c] + 1'b1;
      end
   end

   always_comb begin
      logic [31:0] wide;

      wide         = '0;
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      clr_in       = clr_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      seen_in      = seen_ff;
      count_in     = count_ff;
      out_min_in   = out_min_ff;
      out_max_in   = out_max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pop          = 1'b0;
      rd_en        = 1'b0;
      wr_en        = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = '1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LastAddr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               case (head_cmd.op)
                  OP_CLEAR: begin
                     for (int c = 0; c < NUM_TRACK; c++) begin
                        min_in[c] = '0;
                        max_in[c] = '0;
                     end
                     seen_in  = 1'b0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  OP_PIXEL: begin
                     rd_en = 1'b1;
                     // The first pixel of a frame seeds the extremes.
                     for (int c = 0; c < NUM_TRACK; c++) begin
                        if (head_cmd.track[c]) begin
                           if (!seen_ff || head_cmd.sample[c] < min_ff[c]) begin
                              min_in[c] = head_cmd.sample[c];
                           end
                           if (!seen_ff || head_cmd.sample[c] > max_ff[c]) begin
                              max_in[c] = head_cmd.sample[c];
                           end
                        end
                     end
                     seen_in  = 1'b1;
                     state_in = ST_PIX_WR;
                  end
                  OP_READ: begin
                     rd_en    = 1'b1;
                     state_in = ST_READ_OUT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_PIX_WR: begin
            wr_en    = cmd_ff.bin_ok;
            state_in = ST_IDLE;
         end
         ST_READ_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               for (int c = 0; c < NUM_HIST; c++) begin
                  wide        = 32'(rd_data_ff[c]);
                  count_in[c] = cmd_ff.bin_ok[c] ? wide[OUT_W-1:0] : '0;
               end
               out_min_in   = min_ff[cmd_ff.chan_sel];
               out_max_in   = max_ff[cmd_ff.chan_sel];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_TRACK; c++) begin
            min_ff[c] <= '0;
            max_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      count_ff   <= count_in;
      out_min_ff <= out_min_in;
      out_max_ff <= out_max_in;
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_HIST; c++) begin
         if (wr_en[c]) begin
            bank_mem[c][wr_addr[c]] <= wr_data[c];
         end
         if (rd_en) begin
            rd_data_ff[c] <= bank_mem[c][rd_addr[c]];
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/chm_checker.sv
`default_nettype none

`include "channel_histogram_min_max_assert.svh"

module chm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [chm_pkg::OUT_W-1:0]  rsp_count_first,
   input logic [chm_pkg::OUT_W-1:0]  rsp_channel_min,
   input logic [chm_pkg::OUT_W-1:0]  rsp_channel_max,
   input logic                       csr_psel,
   input logic                       csr_penable,
   input logic                       csr_pwrite,
   input logic [chm_pkg::CSR_AW-1:0] csr_paddr,
   input logic [chm_pkg::CSR_DW-1:0] csr_pwdata,
   input logic [chm_pkg::CSR_DW-1:0] csr_prdata,
   input logic                       csr_pready
);
   import chm_pkg::*;

   logic req_seen;

   assign req_seen = req_valid || req_ready;

   `CHM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

   `CHM_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_count_first) && $stable(rsp_channel_min) && $stable(rsp_channel_max), "response changed while stalled")

   // Reset starts a clearing pass, so nothing is taken and nothing is offered.
   `CHM_ASSERT_ALWAYS(a_reset_clears, reset && (req_seen || !req_seen), !rsp_valid && !req_ready, "block not clearing after reset")

   `CHM_ASSERT_NOW(a_csr_readback, csr_psel && !csr_pwrite && csr_paddr[3:2] == REG_BIN_MODE && !$past(reset) && $past(csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[3:2] == REG_BIN_MODE), csr_prdata == {31'b0, $past(csr_pwdata[0])}, "bin mode readback mismatch")

endmodule

bind channel_histogram_min_max chm_checker u_chm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_count_first (rsp_chan.count_first),
   .rsp_channel_min (rsp_chan.channel_min),
   .rsp_channel_max (rsp_chan.channel_max),
   .csr_psel        (csr_psel),
   .csr_penable     (csr_penable),
   .csr_pwrite      (csr_pwrite),
   .csr_paddr       (csr_paddr),
   .csr_pwdata      (csr_pwdata),
   .csr_prdata      (csr_prdata),
   .csr_pready      (csr_pready)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import chm_pkg::*;

   // The block runs with its default sizes, so the scoreboard model uses them too.
   localparam int BINS = BINS_MAX_DEF;

   // A start request and reset both run a clearing pass that sweeps one bin per cycle.
   // Before a register write the bench waits on top of an empty scoreboard for
   // two such passes, because two starts can sit in the queue behind the last
   // read and neither gives a response to wait for.
   localparam int CLEAR_PAUSE = 2 * (BINS + 1) + 32;

   // Owed responses are drained before the tail, so a short tail is enough to catch
   // anything the block sends that was never asked for.
   localparam int TAIL_CYCLES = 64;

   // Far above the slowest legal run, including the long receiver hold-offs.
   localparam int CYCLE_LIMIT = 2_000_000;

   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASE_ITEMS = 130;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int FIRST_HOLD_AT = 30;
   localparam int SECOND_HOLD_AT = 250;
   localparam int REPORT_LIMIT = 10;
   localparam int RECENT_BIN_DEPTH = 16;

   // The one kind code the block must drop without a response.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Columns of the directed table.
   localparam logic CFG_KEEP = 1'b0;
   localparam logic CFG_WRITE = 1'b1;
   localparam logic PREDICTED = 1'b0;
   localparam logic TYPED = 1'b1;

   typedef struct packed {
      logic [1:0]          kind;
      logic [SAMPLE_W-1:0] sample_zero;
      logic [SAMPLE_W-1:0] sample_one;
      logic [SAMPLE_W-1:0] sample_two;
      logic [SAMPLE_W-1:0] sample_three;
      logic [BIN_W-1:0]    bin_index;
      logic [1:0]          channel_select;
   } request_type;

   typedef struct packed {
      logic [OUT_W-1:0] count_first;
      logic [OUT_W-1:0] count_second;
      logic [OUT_W-1:0] count_third;
      logic [OUT_W-1:0] chan_min;
      logic [OUT_W-1:0] chan_max;
   } readout_type;

   // One row of the directed table: an optional register update done while
   // the block is idle, the request itself, and, for reads whose answer is
   // obvious, the response typed in by hand.
   typedef struct packed {
      logic        cfg_now;
      logic        bin_mode;
      logic        sample_format;
      logic [2:0]  channel_count;
      request_type req;
      logic        typed;
      readout_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   chm_req_if req_bus ();
   chm_rsp_if rsp_bus ();

   channel_histogram_min_max dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scoreboard copy of the histogram: three counters per bin, interleaved by
   // channel, plus the per-channel extremes and the flag that tells whether
   // the current frame has seen a pixel yet.
   logic [COUNT_WIDTH_DEF-1:0] bin_tally [NUM_HIST*BINS];
   logic [SAMPLE_W-1:0]        chan_low  [NUM_TRACK];
   logic [SAMPLE_W-1:0]        chan_high [NUM_TRACK];
   logic                       frame_has_pixel;

   // Register values as the scoreboard believes the block holds them.
   logic       cfg_bin_mode;
   logic       cfg_format;
   logic [2:0] cfg_chan_count;

   // Read responses still owed by the block, oldest first.
   readout_type expected_readouts [$];

   // Bins hit by recent pixels, so that reads mostly land on nonzero counts.
   logic [BIN_W-1:0] recent_bins [$];

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned readouts_taken = 0;
   int unsigned random_items;

   // The directed part. It starts with the reset settings (256 bins, 16-bit
   // samples, three channels), covers both ends of every sample, all request
   // kinds including the unused code, both sample formats and bin counts,
   // channel counts below and above the legal range, and a channel that only
   // becomes tracked in the middle of a frame.
   plan_row_type directed_plan [25] = '{
      // Right after reset every count and every extreme reads as zero.
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'd0, 2'd0, TYPED, 16'd0, 16'd0, 16'd0, 16'h0000, 16'h0000},
      // All-ones and all-zero pixels land in the top and bottom bins.
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'd255, 2'd0, TYPED, 16'd1, 16'd1, 16'd1, 16'h0000, 16'hFFFF},
      // With three channels the fourth one is not tracked and stays at zero.
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'd0, 2'd3, TYPED, 16'd1, 16'd1, 16'd1, 16'h0000, 16'h0000},
      // The unused kind code must leave everything alone.
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_UNUSED, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
       10'h3FF, 2'd3, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'h3FF, 2'd2, TYPED, 16'd0, 16'd0, 16'd0, 16'h0000, 16'hFFFF},
      // A start wipes counts and extremes.
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
       10'h3FF, 2'd3, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'd255, 2'd1, TYPED, 16'd0, 16'd0, 16'd0, 16'h0000, 16'h0000},
      // 1024 bins of 16-bit samples with the fourth channel tracked.
      {CFG_WRITE, 1'b1, 1'b1, 3'd4, KIND_PIXEL, 16'h1234, 16'h8000, 16'hFFFF, 16'hABCD,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_PIXEL, 16'h00FF, 16'h7FFF, 16'h0040, 16'h0000,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'h048, 2'd3, PREDICTED, 80'd0},
      // Ten-bit samples: upper bits and the channel count are ignored.
      {CFG_WRITE, 1'b0, 1'b0, 3'd1, KIND_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_PIXEL, 16'hFFFF, 16'hFC00, 16'h83FF, 16'h1234,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_PIXEL, 16'h0155, 16'h02AA, 16'h0000, 16'hFFFF,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'd255, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'd0, 2'd3, PREDICTED, 80'd0},
      // Ten-bit samples at full resolution, with a channel count above range.
      {CFG_WRITE, 1'b1, 1'b0, 3'd7, KIND_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_PIXEL, 16'h03FF, 16'h0001, 16'h0200, 16'h0000,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'h3FF, 2'd0, PREDICTED, 80'd0},
      // A channel count of zero behaves as one channel.
      {CFG_WRITE, 1'b0, 1'b1, 3'd0, KIND_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_PIXEL, 16'h4000, 16'h8000, 16'hC000, 16'hF000,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'h040, 2'd1, PREDICTED, 80'd0},
      // Widening to four channels mid-frame: the new channels are not seeded,
      // so their minimum stays at zero.
      {CFG_WRITE, 1'b0, 1'b1, 3'd5, KIND_PIXEL, 16'h0100, 16'h0200, 16'h0300, 16'h0400,
       10'd0, 2'd0, PREDICTED, 80'd0},
      {CFG_KEEP, 1'b0, 1'b0, 3'd0, KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
       10'h001, 2'd3, PREDICTED, 80'd0}
   };

   function automatic void clear_frame_model();
      foreach (bin_tally[i]) bin_tally[i] = '0;
      foreach (chan_low[c]) begin
         chan_low[c] = '0;
         chan_high[c] = '0;
      end
      frame_has_pixel = 1'b0;
   endfunction

   // Bin of one sample under the current format and bin count.
   function automatic int bin_of(input logic [SAMPLE_W-1:0] sample);
      logic [3:0] shift;
      if (cfg_format == FORMAT_10B) begin
         shift = cfg_bin_mode ? SHIFT_10B_1024 : SHIFT_10B_256;
         return int'(sample[9:0] >> shift);
      end
      shift = cfg_bin_mode ? SHIFT_16B_1024 : SHIFT_16B_256;
      return int'(sample >> shift);
   endfunction

   // Applies one accepted request to the scoreboard model. Returns 1 when the
   // request owes a response, which is then left in res.
   function automatic bit fold_request(input request_type r, output readout_type res);
      logic [SAMPLE_W-1:0] samples [NUM_TRACK];
      int hist_n;
      int track_n;
      int bin;
      res = '0;
      samples = '{r.sample_zero, r.sample_one, r.sample_two, r.sample_three};
      case (r.kind)
         KIND_START: begin
            clear_frame_model();
         end
         KIND_PIXEL: begin
            if (cfg_format == FORMAT_10B) begin
               // Ten-bit pixels always carry three channels.
               hist_n = NUM_HIST;
               track_n = NUM_HIST;
               foreach (samples[c]) samples[c] = {6'd0, samples[c][9:0]};
            end else begin
               track_n = (cfg_chan_count == 3'd0) ? 1 :
                         (cfg_chan_count > 3'd4) ? NUM_TRACK : int'(cfg_chan_count);
               hist_n = (track_n > NUM_HIST) ? NUM_HIST : track_n;
            end
            for (int c = 0; c < hist_n; c++) begin
               bin = bin_of(samples[c]);
               if (bin < BINS) bin_tally[bin*NUM_HIST + c] += 1'b1;
            end
            for (int c = 0; c < track_n; c++) begin
               if (!frame_has_pixel) begin
                  chan_low[c] = samples[c];
                  chan_high[c] = samples[c];
               end else begin
                  if (samples[c] < chan_low[c]) chan_low[c] = samples[c];
                  if (samples[c] > chan_high[c]) chan_high[c] = samples[c];
               end
            end
            frame_has_pixel = 1'b1;
         end
         KIND_READ: begin
            if (r.bin_index < BINS) begin
               res.count_first = bin_tally[r.bin_index*NUM_HIST];
               res.count_second = bin_tally[r.bin_index*NUM_HIST + 1];
               res.count_third = bin_tally[r.bin_index*NUM_HIST + 2];
            end
            res.chan_min = chan_low[r.channel_select];
            res.chan_max = chan_high[r.channel_select];
            return 1'b1;
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   // Idle cycles before a request: mostly none, sometimes a few, rarely many.
   function automatic int unsigned pick_gap(input logic dense);
      int unsigned roll;
      if (dense) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Samples cluster around a per-frame base so that bins collect counts,
   // with fully random values and both extremes mixed in.
   function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] base);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return SAMPLE_W'($urandom);
      if (roll < 90) return base + SAMPLE_W'($urandom_range(0, 255));
      if (roll < 95) return '0;
      return '1;
   endfunction

   // Two-phase register write. The register takes the value at the edge of
   // the access phase; the select is then dropped to keep back-to-back writes apart.
   task automatic csr_write(input logic [1:0] index, input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering requests, waits for every owed response and then for the
   // clearing passes that may still be queued, after which the block is
   // certain to be idle.
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      while (expected_readouts.size() != 0) @(posedge clock);
      repeat (CLEAR_PAUSE) @(posedge clock);
   endtask

   task automatic apply_config(input logic bin_mode, input logic sample_format,
                               input logic [2:0] channel_count);
      wait_until_idle();
      csr_write(REG_BIN_MODE, CSR_DW'(bin_mode));
      csr_write(REG_SAMPLE_FORMAT, CSR_DW'(sample_format));
      csr_write(REG_CHANNEL_COUNT, CSR_DW'(channel_count));
      cfg_bin_mode = bin_mode;
      cfg_format = sample_format;
      cfg_chan_count = channel_count;
   endtask

   // Offers one request after the given gap and holds it until accepted. If
   // the gap is zero, valid simply stays high from the previous request.
   task automatic issue_request(input request_type r, input int unsigned gap,
                                input logic typed, input readout_type want);
      readout_type predicted;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.kind <= r.kind;
      req_bus.sample_zero <= r.sample_zero;
      req_bus.sample_one <= r.sample_one;
      req_bus.sample_two <= r.sample_two;
      req_bus.sample_three <= r.sample_three;
      req_bus.bin_index <= r.bin_index;
      req_bus.channel_select <= r.channel_select;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      if (fold_request(r, predicted)) expected_readouts.push_back(typed ? want : predicted);
      if (r.kind == KIND_PIXEL) begin
         recent_bins.push_back(BIN_W'(bin_of(r.sample_zero)));
         if (recent_bins.size() > RECENT_BIN_DEPTH) void'(recent_bins.pop_front());
      end
   endtask

   // Stimulus: reset, the directed table, then random phases. Each phase
   // writes a new register setting and runs a series of frames; a frame is a
   // start followed by pixels and reads, with a few unused codes and stray
   // starts mixed in. The first eight phases walk every channel count and
   // every pairing of format and bin count; later ones pick settings at random.
   initial begin
      request_type r;
      readout_type no_readout;
      int unsigned frame_len;
      int unsigned roll;
      int unsigned phase_items;
      int          phase;
      logic        dense;
      logic        phase_bin_mode;
      logic        phase_format;
      logic [2:0]  phase_chan_count;
      logic [SAMPLE_W-1:0] base;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.kind <= KIND_START;
      req_bus.sample_zero <= '0;
      req_bus.sample_one <= '0;
      req_bus.sample_two <= '0;
      req_bus.sample_three <= '0;
      req_bus.bin_index <= '0;
      req_bus.channel_select <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;

      no_readout = '0;
      cfg_bin_mode = 1'b0;
      cfg_format = 1'b1;
      cfg_chan_count = 3'd3;
      clear_frame_model();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].cfg_now == CFG_WRITE)
            apply_config(directed_plan[i].bin_mode, directed_plan[i].sample_format,
                         directed_plan[i].channel_count);
         issue_request(directed_plan[i].req, pick_gap(1'b0), directed_plan[i].typed,
                       directed_plan[i].want);
      end

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase < 8) begin
            phase_bin_mode = phase[0];
            phase_format = phase[1];
            phase_chan_count = phase[2:0];
         end else begin
            phase_bin_mode = 1'($urandom);
            phase_format = 1'($urandom);
            phase_chan_count = 3'($urandom_range(0, 7));
         end
         apply_config(phase_bin_mode, phase_format, phase_chan_count);

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            r = request_type'({$urandom, $urandom, $urandom});
            r.kind = KIND_START;
            issue_request(r, pick_gap(1'b0), PREDICTED, no_readout);
            phase_items++;

            // About one frame in four runs with no idle cycles at all.
            frame_len = $urandom_range(10, 50);
            dense = ($urandom_range(0, 3) == 0);
            base = SAMPLE_W'($urandom);
            repeat (frame_len) begin
               r.sample_zero = pick_sample(base);
               r.sample_one = pick_sample(base);
               r.sample_two = pick_sample(base);
               r.sample_three = pick_sample(base);
               r.channel_select = 2'($urandom);
               if (recent_bins.size() != 0 && $urandom_range(0, 9) < 7)
                  r.bin_index = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
               else
                  r.bin_index = BIN_W'($urandom);
               roll = $urandom_range(0, 99);
               if (roll < 64) r.kind = KIND_PIXEL;
               else if (roll < 92) r.kind = KIND_READ;
               else if (roll < 96) r.kind = KIND_UNUSED;
               else r.kind = KIND_START;
               issue_request(r, pick_gap(dense), PREDICTED, no_readout);
               if (r.kind != KIND_UNUSED) phase_items++;
            end
         end
         random_items += phase_items;
         phase++;
      end

      req_bus.valid <= 1'b0;
      while (expected_readouts.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_readouts.size() == 0)
         $display("channel_histogram_min_max regression: pass");
      else
         $display("channel_histogram_min_max regression: fail");
      $finish;
   end

   // Response side. Each accepted response is matched against the oldest
   // owed read. The ready line alternates between runs and stalls of random
   // length, and twice it holds off for a long stretch while the sender keeps
   // going, so that the output register, the request queue and finally the
   // request channel all back up.
   initial begin
      int unsigned stall_left;
      int unsigned run_left;
      int unsigned holds_done;
      int unsigned roll;
      readout_type got;
      readout_type want;

      stall_left = 0;
      run_left = 0;
      holds_done = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.count_first, rsp_bus.count_second, rsp_bus.count_third,
                   rsp_bus.channel_min, rsp_bus.channel_max};
            readouts_taken++;
            if (expected_readouts.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: response %0d arrived with no read outstanding: %h %h %h %h %h",
                           $realtime, readouts_taken, got.count_first, got.count_second,
                           got.count_third, got.chan_min, got.chan_max);
            end else begin
               want = expected_readouts.pop_front();
               if (got.count_first !== want.count_first ||
                   got.count_second !== want.count_second ||
                   got.count_third !== want.count_third ||
                   got.chan_min !== want.chan_min || got.chan_max !== want.chan_max) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: response %0d: counts %h %h %h min %h max %h, %s %h %h %h %s %h %s %h",
                              $realtime, readouts_taken, got.count_first, got.count_second,
                              got.count_third, got.chan_min, got.chan_max, "expected",
                              want.count_first, want.count_second, want.count_third,
                              "min", want.chan_min, "max", want.chan_max);
               end
            end
         end

         if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (run_left != 0) begin
            run_left--;
            rsp_bus.ready <= 1'b1;
         end else if ((holds_done == 0 && readouts_taken >= FIRST_HOLD_AT) ||
                      (holds_done == 1 && readouts_taken >= SECOND_HOLD_AT)) begin
            holds_done++;
            stall_left = HOLD_OFF_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
               run_left = (roll < 10) ? $urandom_range(40, 120) : $urandom_range(0, 20);
               rsp_bus.ready <= 1'b1;
            end else begin
               if (roll < 90) stall_left = $urandom_range(0, 2);
               else if (roll < 97) stall_left = $urandom_range(3, 12);
               else stall_left = $urandom_range(20, 80);
               rsp_bus.ready <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("channel_histogram_min_max regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/chm_pkg.sv
rtl/chm_channel_if.sv
rtl/chm_front.sv
rtl/chm_queue.sv
rtl/chm_back.sv
rtl/channel_histogram_min_max.sv
rtl/chm_checker.sv
tb/sv/tb_top.sv
